// ===== sv/iou_track_table_macros.svh =====
// Assertion shorthands for the tracker back end (iou_back).
`ifndef IOU_TRACK_TABLE_MACROS_SVH
`define IOU_TRACK_TABLE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define IOU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define IOU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/iou_pkg.sv =====
`timescale 1ns / 1ps
package iou_pkg;

    localparam int MAX_TRACKS_DEF = 16;
    localparam int Q_DEPTH        = 2;
    localparam int BLEND_FIELDS   = 6;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_DETECT = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    localparam logic [1:0] CFG_LOST_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_MATCH_THRESH = 2'd1;
    localparam logic [1:0] CFG_BLEND_WEIGHT = 2'd2;

    localparam logic [7:0] LOST_LIMIT_RST   = 8'd5;
    localparam logic [8:0] MATCH_THRESH_RST = 9'd77;
    localparam logic [8:0] BLEND_WEIGHT_RST = 9'd128;
    localparam logic [8:0] WEIGHT_ONE       = 9'd256;
    localparam logic [15:0] ID_FIRST        = 16'd1;
    localparam logic [15:0] ID_MAX          = 16'hFFFF;
    localparam logic [7:0] LOST_MAX         = 8'hFF;

    localparam logic [2:0] FLD_LEFT     = 3'd0;
    localparam logic [2:0] FLD_TOP      = 3'd1;
    localparam logic [2:0] FLD_RIGHT    = 3'd2;
    localparam logic [2:0] FLD_BOTTOM   = 3'd3;
    localparam logic [2:0] FLD_ANGLE    = 3'd4;
    localparam logic [2:0] FLD_DISTANCE = 3'd5;

    typedef enum logic [1:0] {
        OP_START,
        OP_DETECT,
        OP_REPORT
    } op_t;

    // first field in the highest bits
    typedef struct packed {
        logic [15:0] distance;
        logic [11:0] angle;
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
        logic [7:0]  score;
        logic [7:0]  obj_class;
    } det_t;

    typedef struct packed {
        op_t  op;
        det_t det;
    } q_item_t;

    typedef struct packed {
        logic [7:0]  lost;
        logic [15:0] distance;
        logic [11:0] angle;
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
        logic [7:0]  score;
        logic [7:0]  obj_class;
        logic [15:0] id;
    } rec_t;

    typedef struct packed {
        logic [7:0] lost_limit;
        logic [8:0] match_threshold;
        logic [8:0] blend_weight;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AGE_RD,
        ST_AGE_WR,
        ST_DET_RD,
        ST_DET_SPAN,
        ST_DET_MUL,
        ST_DET_UNI,
        ST_DET_CROSS,
        ST_DET_CMP,
        ST_DET_THR,
        ST_DET_DEC,
        ST_BL_RD,
        ST_BL_MUL,
        ST_BL_WR,
        ST_NEW,
        ST_ER_RD,
        ST_ER_CHK,
        ST_PK_RD,
        ST_PK_CHK,
        ST_PK_EMIT,
        ST_EMPTY
    } state_t;

    function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
        return (hi > lo) ? hi - lo : 16'd0;
    endfunction

    function automatic logic signed [16:0] rec_field(input rec_t r, input logic [2:0] k);
        logic signed [16:0] v;
        v = '0;
        unique case (k)
            FLD_LEFT:     v = $signed({1'b0, r.left});
            FLD_TOP:      v = $signed({1'b0, r.top});
            FLD_RIGHT:    v = $signed({1'b0, r.right});
            FLD_BOTTOM:   v = $signed({1'b0, r.bottom});
            FLD_ANGLE:    v = 17'($signed(r.angle));
            FLD_DISTANCE: v = $signed({1'b0, r.distance});
            default:      v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] det_field(input det_t d, input logic [2:0] k);
        logic signed [16:0] v;
        v = '0;
        unique case (k)
            FLD_LEFT:     v = $signed({1'b0, d.left});
            FLD_TOP:      v = $signed({1'b0, d.top});
            FLD_RIGHT:    v = $signed({1'b0, d.right});
            FLD_BOTTOM:   v = $signed({1'b0, d.bottom});
            FLD_ANGLE:    v = 17'($signed(d.angle));
            FLD_DISTANCE: v = $signed({1'b0, d.distance});
            default:      v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/iou_ram.sv =====
`timescale 1ns / 1ps
module iou_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/iou_front.sv =====
`timescale 1ns / 1ps
module iou_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [111:0]    s_axis_tdata,
    input  logic [1:0]      s_axis_tuser,
    output logic            q_valid,
    output iou_pkg::q_item_t q_item,
    input  logic            q_pop
);
    import iou_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    q_item_t           q_mem [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              accept;
    logic              push;
    logic              pop;
    q_item_t           item_in;

    assign s_axis_tready = (cnt_reg < CNT_W'(Q_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != '0);
    assign q_item        = q_mem[rd_ptr_reg];
    assign pop           = q_pop && q_valid;

    // classify the command; the unused code is dropped here
    always_comb
    begin
        item_in.det = det_t'(s_axis_tdata[$bits(det_t)-1:0]);
        item_in.op  = OP_START;
        push        = 1'b0;
        unique case (s_axis_tuser)
            CMD_START:
            begin
                item_in.op = OP_START;
                push       = accept;
            end
            CMD_DETECT:
            begin
                item_in.op = OP_DETECT;
                push       = accept;
            end
            CMD_REPORT:
            begin
                item_in.op = OP_REPORT;
                push       = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end
endmodule

// ===== sv/iou_back.sv =====
`timescale 1ns / 1ps
`include "iou_track_table_macros.svh"
module iou_back #(
    parameter int MAX_TRACKS = iou_pkg::MAX_TRACKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  iou_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  iou_pkg::q_item_t q_item,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [135:0]     m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser
);
    import iou_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TRACKS);
    localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
    localparam int REC_W  = $bits(rec_t);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TRACKS - 1);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [MAX_TRACKS-1:0] used_reg, used_next;
    logic [MAX_TRACKS-1:0] done_reg, done_next;
    det_t                det_reg, det_next;
    logic                drop_reg, drop_next;
    logic [15:0]         next_id_reg, next_id_next;

    logic [15:0] wi_reg, wi_next, hi_reg, hi_next;
    logic [15:0] wa_reg, wa_next, ha_reg, ha_next;
    logic [15:0] wb_reg, wb_next, hb_reg, hb_next;
    logic [15:0] cand_id_reg, cand_id_next;
    logic [31:0] inter_reg, inter_next;
    logic [31:0] area_a_reg, area_a_next, area_b_reg, area_b_next;
    logic [32:0] uni_reg, uni_next;
    logic [64:0] p1_reg, p1_next, p2_reg, p2_next;

    logic              best_found_reg, best_found_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;
    logic [15:0]       best_id_reg, best_id_next;
    logic [31:0]       best_i_reg, best_i_next;
    logic [32:0]       best_u_reg, best_u_next;
    logic [41:0]       thr_lhs_reg, thr_lhs_next, thr_rhs_reg, thr_rhs_next;

    logic [2:0]  k_reg, k_next;
    logic [15:0] bl_res_reg [BLEND_FIELDS];
    logic [15:0] bl_res_next;
    logic        bl_we;

    logic [CNT_W-1:0]  live_reg, live_next;
    logic              pick_found_reg, pick_found_next;
    logic [SLOT_W-1:0] pick_slot_reg, pick_slot_next;
    rec_t              pick_rec_reg, pick_rec_next;

    logic out_valid_reg, out_valid_next;
    rec_t out_rec_reg, out_rec_next;
    logic out_drop_reg, out_drop_next;
    logic out_last_reg, out_last_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    rec_t              ram_wdata;
    logic [REC_W-1:0]  ram_rdata;
    rec_t              rec_rd;

    logic              idx_last;
    logic              out_free;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              er_keep;
    logic [CNT_W-1:0]  er_live;
    logic              det_match;
    logic [8:0]        w_eff;
    logic signed [17:0] bl_diff;
    logic signed [27:0] bl_prod;
    logic signed [17:0] bl_sum;
    logic signed [16:0] bl_old;

    iou_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_TRACKS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rec_rd    = rec_t'(ram_rdata);
    assign idx_last  = (idx_reg == LAST_SLOT);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign ram_raddr = (state_reg == ST_BL_RD || state_reg == ST_BL_MUL || state_reg == ST_BL_WR)
                       ? best_slot_reg : idx_reg;
    assign er_keep   = used_reg[idx_reg] && (rec_rd.lost <= cfg.lost_limit);
    assign er_live   = live_reg + CNT_W'(er_keep);
    assign det_match = best_found_reg && ({1'b0, thr_lhs_reg} >= {1'b0, thr_rhs_reg});
    assign w_eff     = (cfg.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.blend_weight;

    // blend one field per cycle: old + floor(w * (det - old) / 256)
    assign bl_old      = rec_field(rec_rd, k_reg);
    assign bl_diff     = 18'(det_field(det_reg, k_reg)) - 18'(bl_old);
    assign bl_prod     = $signed({1'b0, w_eff}) * bl_diff;
    assign bl_sum      = 18'(bl_old) + 18'(bl_prod >>> 8);
    assign bl_res_next = bl_sum[15:0];

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = MAX_TRACKS - 1; s >= 0; s--)
        begin
            if (!used_reg[s])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op)
                        OP_START:  state_next = ST_AGE_RD;
                        OP_DETECT: state_next = ST_DET_RD;
                        OP_REPORT: state_next = ST_ER_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_AGE_RD:    state_next = ST_AGE_WR;
            ST_AGE_WR:    state_next = idx_last ? ST_IDLE : ST_AGE_RD;
            ST_DET_RD:
            begin
                if (used_reg[idx_reg])
                begin
                    state_next = ST_DET_SPAN;
                end
                else
                begin
                    state_next = idx_last ? ST_DET_THR : ST_DET_RD;
                end
            end
            ST_DET_SPAN:
            begin
                if (rec_rd.obj_class == det_reg.obj_class)
                begin
                    state_next = ST_DET_MUL;
                end
                else
                begin
                    state_next = idx_last ? ST_DET_THR : ST_DET_RD;
                end
            end
            ST_DET_MUL:   state_next = ST_DET_UNI;
            ST_DET_UNI:   state_next = ST_DET_CROSS;
            ST_DET_CROSS:
            begin
                if (uni_reg != '0)
                begin
                    state_next = ST_DET_CMP;
                end
                else
                begin
                    state_next = idx_last ? ST_DET_THR : ST_DET_RD;
                end
            end
            ST_DET_CMP:   state_next = idx_last ? ST_DET_THR : ST_DET_RD;
            ST_DET_THR:   state_next = ST_DET_DEC;
            ST_DET_DEC:   state_next = det_match ? ST_BL_RD : ST_NEW;
            ST_BL_RD:     state_next = ST_BL_MUL;
            ST_BL_MUL:    state_next = (k_reg == FLD_DISTANCE) ? ST_BL_WR : ST_BL_MUL;
            ST_BL_WR:     state_next = ST_IDLE;
            ST_NEW:       state_next = ST_IDLE;
            ST_ER_RD:     state_next = ST_ER_CHK;
            ST_ER_CHK:
            begin
                if (!idx_last)
                begin
                    state_next = ST_ER_RD;
                end
                else
                begin
                    state_next = (er_live == '0) ? ST_EMPTY : ST_PK_RD;
                end
            end
            ST_PK_RD:     state_next = ST_PK_CHK;
            ST_PK_CHK:    state_next = idx_last ? ST_PK_EMIT : ST_PK_RD;
            ST_PK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (live_reg == CNT_W'(1)) ? ST_IDLE : ST_PK_RD;
                end
            end
            ST_EMPTY:     state_next = out_free ? ST_IDLE : ST_EMPTY;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop           = 1'b0;
        idx_next        = idx_reg;
        used_next       = used_reg;
        done_next       = done_reg;
        det_next        = det_reg;
        drop_next       = drop_reg;
        next_id_next    = next_id_reg;
        wi_next         = wi_reg;
        hi_next         = hi_reg;
        wa_next         = wa_reg;
        ha_next         = ha_reg;
        wb_next         = wb_reg;
        hb_next         = hb_reg;
        cand_id_next    = cand_id_reg;
        inter_next      = inter_reg;
        area_a_next     = area_a_reg;
        area_b_next     = area_b_reg;
        uni_next        = uni_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_id_next    = best_id_reg;
        best_i_next     = best_i_reg;
        best_u_next     = best_u_reg;
        thr_lhs_next    = thr_lhs_reg;
        thr_rhs_next    = thr_rhs_reg;
        k_next          = k_reg;
        bl_we           = 1'b0;
        live_next       = live_reg;
        pick_found_next = pick_found_reg;
        pick_slot_next  = pick_slot_reg;
        pick_rec_next   = pick_rec_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_rec_next    = out_rec_reg;
        out_drop_next   = out_drop_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = rec_rd;

        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop           = q_valid;
                idx_next        = '0;
                det_next        = q_item.det;
                best_found_next = 1'b0;
                best_i_next     = '0;
                best_u_next     = 33'd1;
                live_next       = '0;
                done_next       = '0;
                pick_found_next = 1'b0;
                if (q_valid && q_item.op == OP_START)
                begin
                    drop_next = 1'b0;
                end
            end
            ST_AGE_RD:
            begin
            end
            ST_AGE_WR:
            begin
                ram_we    = used_reg[idx_reg];
                if (rec_rd.lost != LOST_MAX)
                begin
                    ram_wdata.lost = rec_rd.lost + 1'b1;
                end
                idx_next  = idx_reg + 1'b1;
            end
            ST_DET_RD:
            begin
                if (!used_reg[idx_reg])
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DET_SPAN:
            begin
                wi_next = span16((rec_rd.left > det_reg.left) ? rec_rd.left : det_reg.left,
                                 (rec_rd.right < det_reg.right) ? rec_rd.right : det_reg.right);
                hi_next = span16((rec_rd.top > det_reg.top) ? rec_rd.top : det_reg.top,
                                 (rec_rd.bottom < det_reg.bottom) ? rec_rd.bottom : det_reg.bottom);
                wa_next = span16(rec_rd.left, rec_rd.right);
                ha_next = span16(rec_rd.top, rec_rd.bottom);
                wb_next = span16(det_reg.left, det_reg.right);
                hb_next = span16(det_reg.top, det_reg.bottom);
                cand_id_next = rec_rd.id;
                if (rec_rd.obj_class != det_reg.obj_class)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DET_MUL:
            begin
                inter_next  = wi_reg * hi_reg;
                area_a_next = wa_reg * ha_reg;
                area_b_next = wb_reg * hb_reg;
            end
            ST_DET_UNI:
            begin
                uni_next = 33'(area_a_reg) + 33'(area_b_reg) - 33'(inter_reg);
            end
            ST_DET_CROSS:
            begin
                p1_next = 65'(inter_reg) * 65'(best_u_reg);
                p2_next = 65'(best_i_reg) * 65'(uni_reg);
                if (uni_reg == '0)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DET_CMP:
            begin
                // strictly better, or an exact tie won by the lower id
                if ((p1_reg > p2_reg) ||
                    (best_found_reg && !(p2_reg > p1_reg) && cand_id_reg < best_id_reg))
                begin
                    best_found_next = 1'b1;
                    best_slot_next  = idx_reg;
                    best_id_next    = cand_id_reg;
                    best_i_next     = inter_reg;
                    best_u_next     = uni_reg;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_DET_THR:
            begin
                thr_lhs_next = {2'b00, best_i_reg, 8'h00};
                thr_rhs_next = 42'(cfg.match_threshold) * 42'(best_u_reg);
                k_next       = FLD_LEFT;
            end
            ST_DET_DEC:
            begin
            end
            ST_BL_RD:
            begin
            end
            ST_BL_MUL:
            begin
                bl_we  = 1'b1;
                k_next = k_reg + 1'b1;
            end
            ST_BL_WR:
            begin
                ram_we             = 1'b1;
                ram_waddr          = best_slot_reg;
                ram_wdata.left     = bl_res_reg[FLD_LEFT];
                ram_wdata.top      = bl_res_reg[FLD_TOP];
                ram_wdata.right    = bl_res_reg[FLD_RIGHT];
                ram_wdata.bottom   = bl_res_reg[FLD_BOTTOM];
                ram_wdata.angle    = bl_res_reg[FLD_ANGLE][11:0];
                ram_wdata.distance = bl_res_reg[FLD_DISTANCE];
                ram_wdata.score    = det_reg.score;
                ram_wdata.lost     = '0;
            end
            ST_NEW:
            begin
                if (free_found)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = free_slot;
                    ram_wdata.id         = next_id_reg;
                    ram_wdata.obj_class  = det_reg.obj_class;
                    ram_wdata.score      = det_reg.score;
                    ram_wdata.left       = det_reg.left;
                    ram_wdata.top        = det_reg.top;
                    ram_wdata.right      = det_reg.right;
                    ram_wdata.bottom     = det_reg.bottom;
                    ram_wdata.angle      = det_reg.angle;
                    ram_wdata.distance   = det_reg.distance;
                    ram_wdata.lost       = '0;
                    used_next[free_slot] = 1'b1;
                    next_id_next = (next_id_reg == ID_MAX) ? ID_FIRST : next_id_reg + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
            ST_ER_RD:
            begin
            end
            ST_ER_CHK:
            begin
                if (used_reg[idx_reg] && !er_keep)
                begin
                    used_next[idx_reg] = 1'b0;
                end
                live_next = er_live;
                // restart the sweep at slot zero for the pick pass
                idx_next  = idx_last ? '0 : idx_reg + 1'b1;
            end
            ST_PK_RD:
            begin
            end
            ST_PK_CHK:
            begin
                if (used_reg[idx_reg] && !done_reg[idx_reg] &&
                    (!pick_found_reg || rec_rd.id < pick_rec_reg.id))
                begin
                    pick_found_next = 1'b1;
                    pick_slot_next  = idx_reg;
                    pick_rec_next   = rec_rd;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_PK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_rec_next            = pick_rec_reg;
                    out_drop_next           = drop_reg;
                    out_last_next           = (live_reg == CNT_W'(1));
                    done_next[pick_slot_reg] = 1'b1;
                    live_next               = live_reg - 1'b1;
                    pick_found_next         = 1'b0;
                    idx_next                = '0;
                    if (live_reg == CNT_W'(1))
                    begin
                        drop_next = 1'b0;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = '0;
                    out_drop_next  = drop_reg;
                    out_last_next  = 1'b1;
                    drop_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            drop_reg       <= 1'b0;
            next_id_reg    <= ID_FIRST;
            out_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            pick_found_reg <= 1'b0;
            live_reg       <= '0;
            done_reg       <= '0;
            idx_reg        <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            drop_reg       <= drop_next;
            next_id_reg    <= next_id_next;
            out_valid_reg  <= out_valid_next;
            best_found_reg <= best_found_next;
            pick_found_reg <= pick_found_next;
            live_reg       <= live_next;
            done_reg       <= done_next;
            idx_reg        <= idx_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg       <= det_next;
        wi_reg        <= wi_next;
        hi_reg        <= hi_next;
        wa_reg        <= wa_next;
        ha_reg        <= ha_next;
        wb_reg        <= wb_next;
        hb_reg        <= hb_next;
        cand_id_reg   <= cand_id_next;
        inter_reg     <= inter_next;
        area_a_reg    <= area_a_next;
        area_b_reg    <= area_b_next;
        uni_reg       <= uni_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        best_slot_reg <= best_slot_next;
        best_id_reg   <= best_id_next;
        best_i_reg    <= best_i_next;
        best_u_reg    <= best_u_next;
        thr_lhs_reg   <= thr_lhs_next;
        thr_rhs_reg   <= thr_rhs_next;
        pick_slot_reg <= pick_slot_next;
        pick_rec_reg  <= pick_rec_next;
        out_rec_reg   <= out_rec_next;
        out_drop_reg  <= out_drop_next;
        out_last_reg  <= out_last_next;
        if (bl_we)
        begin
            bl_res_reg[k_reg] <= bl_res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_rec_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_drop_reg;

    `IOU_ASSERT_ALWAYS(a_id_nonzero, next_id_reg != 16'd0, "next track id reached zero")
    `IOU_ASSERT_IMPLY(a_emit_has_pick, state_reg == ST_PK_EMIT, pick_found_reg,
        "report record without a picked track")
    `IOU_ASSERT_IMPLY(a_live_count,
        state_reg == ST_PK_RD || state_reg == ST_PK_CHK || state_reg == ST_PK_EMIT,
        $countones(used_reg & ~done_reg) == 32'(live_reg),
        "remaining record count out of step with live tracks")
endmodule

// ===== sv/iou_track_table.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload
// s_axis    in   tdata: det_class, det_score, det_left, det_top, det_right,
//                det_bottom, det_angle, det_distance; tuser: command
// m_axis    out  tdata: out_id .. out_lost; tuser: out_dropped; tlast: out_last
// cfg       in   cfg_we, cfg_index, cfg_data (no read-back)
//
// Frame start: one slot-memory read per slot and a write per used slot.
// Detection: per slot, a free slot is skipped, another class stops after the slot
// read, and the same class runs a shared IoU multiply chain; then the item is
// thresholded and decided, and either blended or starts a new track or is dropped.
// Frame end: one sweep to take the item and erase, then one min-id sweep of the
// slot memory per reported track, or a single empty record if none is live.
// Reset clears the per-slot used bits but not the slot memory, which needs no clearing.
// A two-entry input queue keeps taking items until full while the sequencer
// works; a stalled output holds its register and the next record waits behind it.
module iou_track_table #(
    parameter int MAX_TRACKS = iou_pkg::MAX_TRACKS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // det_class, det_score, det_left, det_top,
                                        // det_right, det_bottom, det_angle, det_distance
    input  logic [1:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // out_id, out_class, out_score, out_left, out_top,
                                        // out_right, out_bottom, out_angle, out_distance,
                                        // out_lost
    output logic         m_axis_tlast,
    output logic [0:0]   m_axis_tuser,  // out_dropped
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);
    import iou_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOST_LIMIT:   cfg_next.lost_limit      = cfg_data[7:0];
                CFG_MATCH_THRESH: cfg_next.match_threshold = cfg_data;
                CFG_BLEND_WEIGHT: cfg_next.blend_weight    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_limit      <= LOST_LIMIT_RST;
            cfg_reg.match_threshold <= MATCH_THRESH_RST;
            cfg_reg.blend_weight    <= BLEND_WEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    iou_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    iou_back #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );
endmodule

// ===== verif/iou_track_table_tb.sv =====
`timescale 1ns / 1ps
module iou_track_table_tb;
    import iou_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        rec_t r;
        logic dropped;
        logic last;
    } track_rec_t;

    class track_scoreboard;
        rec_t        slot[NSLOT];
        bit          used[NSLOT];
        logic [15:0] next_id;
        bit          drop_flag;
        logic [7:0]  lost_limit;
        logic [8:0]  match_thr;
        logic [8:0]  weight;
        track_rec_t  expected_recs[$];
        int          mismatches;
        int          failures;

        function new();
            foreach (used[s]) used[s] = 0;
            next_id = ID_FIRST;
            drop_flag = 0;
            lost_limit = LOST_LIMIT_RST;
            match_thr = MATCH_THRESH_RST;
            weight = BLEND_WEIGHT_RST;
            mismatches = 0;
            failures = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [8:0] val);
            case (idx)
                CFG_LOST_LIMIT:   lost_limit = val[7:0];
                CFG_MATCH_THRESH: match_thr = val;
                CFG_BLEND_WEIGHT: weight = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_recs.size();
        endfunction

        static function logic [127:0] span(logic [15:0] lo, logic [15:0] hi);
            return (hi > lo) ? 128'(hi - lo) : 128'd0;
        endfunction

        // floor of the weighted mix, also for negative values
        static function int mix(int det, int old, int w);
            int sum;
            sum = w * det + (256 - w) * old;
            return sum >>> 8;
        endfunction

        function void overlap(rec_t a, det_t b, output logic [127:0] i, output logic [127:0] u);
            logic [15:0] il, it, ir, ib;
            il = (a.left > b.left) ? a.left : b.left;
            it = (a.top > b.top) ? a.top : b.top;
            ir = (a.right < b.right) ? a.right : b.right;
            ib = (a.bottom < b.bottom) ? a.bottom : b.bottom;
            i = span(il, ir) * span(it, ib);
            u = span(a.left, a.right) * span(a.top, a.bottom)
                + span(b.left, b.right) * span(b.top, b.bottom) - i;
        endfunction

        function void detect(det_t d);
            int best;
            int w;
            int s;
            logic [127:0] bi, bu, i, u;
            best = -1;
            bi = 0;
            bu = 1;
            for (s = 0; s < NSLOT; s++) begin
                if (!used[s] || slot[s].obj_class != d.obj_class) continue;
                overlap(slot[s], d, i, u);
                if (u == 0) continue;
                if (i * bu > bi * u) begin
                    best = s;
                    bi = i;
                    bu = u;
                end else if (best >= 0 && !(bi * u > i * bu) && slot[s].id < slot[best].id) begin
                    best = s;
                end
            end
            if (best >= 0 && bi * 256 >= 128'(match_thr) * bu) begin
                w = (weight > WEIGHT_ONE) ? 256 : int'(weight);
                slot[best].left = 16'(mix(d.left, slot[best].left, w));
                slot[best].top = 16'(mix(d.top, slot[best].top, w));
                slot[best].right = 16'(mix(d.right, slot[best].right, w));
                slot[best].bottom = 16'(mix(d.bottom, slot[best].bottom, w));
                slot[best].angle = 12'(mix($signed(d.angle), $signed(slot[best].angle), w));
                slot[best].distance = 16'(mix(d.distance, slot[best].distance, w));
                slot[best].score = d.score;
                slot[best].lost = '0;
                return;
            end
            for (s = 0; s < NSLOT; s++)
                if (!used[s]) break;
            if (s >= NSLOT) begin
                drop_flag = 1;
                return;
            end
            used[s] = 1;
            slot[s].id = next_id;
            slot[s].obj_class = d.obj_class;
            slot[s].score = d.score;
            slot[s].left = d.left;
            slot[s].top = d.top;
            slot[s].right = d.right;
            slot[s].bottom = d.bottom;
            slot[s].angle = d.angle;
            slot[s].distance = d.distance;
            slot[s].lost = '0;
            next_id = (next_id == ID_MAX) ? ID_FIRST : next_id + 16'd1;
        endfunction

        function void report();
            bit done[NSLOT];
            int pick;
            int n;
            track_rec_t e;
            n = 0;
            foreach (used[s]) begin
                if (used[s] && slot[s].lost > lost_limit) used[s] = 0;
                done[s] = 0;
            end
            forever begin
                pick = -1;
                foreach (used[s])
                    if (used[s] && !done[s] && (pick < 0 || slot[s].id < slot[pick].id))
                        pick = s;
                if (pick < 0) break;
                done[pick] = 1;
                e.r = slot[pick];
                e.dropped = drop_flag;
                e.last = 0;
                expected_recs = {expected_recs, e};
                n++;
            end
            if (n == 0) begin
                e = '0;
                e.dropped = drop_flag;
                expected_recs = {expected_recs, e};
            end
            expected_recs[expected_recs.size() - 1].last = 1;
            drop_flag = 0;
        endfunction

        function void note_command(logic [1:0] cmd, det_t d);
            case (cmd)
                CMD_START: begin
                    foreach (used[s])
                        if (used[s] && slot[s].lost != LOST_MAX) slot[s].lost++;
                    drop_flag = 0;
                end
                CMD_DETECT: detect(d);
                CMD_REPORT: report();
                default: ;
            endcase
        endfunction

        function void check_record(track_rec_t got);
            track_rec_t e;
            if (expected_recs.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected record %p", got);
                return;
            end
            e = expected_recs.pop_front();
            if (got.r.id !== e.r.id || got.r.obj_class !== e.r.obj_class
                || got.r.score !== e.r.score || got.r.left !== e.r.left
                || got.r.top !== e.r.top || got.r.right !== e.r.right
                || got.r.bottom !== e.r.bottom || got.r.angle !== e.r.angle
                || got.r.distance !== e.r.distance || got.r.lost !== e.r.lost
                || got.dropped !== e.dropped || got.last !== e.last) begin
                mismatches++;
                failures++;
                if (mismatches <= 10)
                    $display("record mismatch: expected %p got %p", e, got);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic [0:0]   m_axis_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [8:0]   cfg_data;

    track_scoreboard sb;
    bit   no_idle;
    bit   rx_hold_req;
    int   items_sent;
    det_t recent_boxes[$];

    iou_track_table u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("iou_track_table verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_command(s_axis_tuser, det_t'(s_axis_tdata[107:0]));
    end

    always @(posedge clk)
    begin
        track_rec_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.r = rec_t'(m_axis_tdata[131:0]);
            got.dropped = m_axis_tuser[0];
            got.last = m_axis_tlast;
            sb.check_record(got);
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_axis_tready = 0;
        @(posedge rst_n);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge clk);
                rx_hold_req = 0;
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic det_t rand_det_bits();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return det_t'(raw[107:0]);
    endfunction

    task automatic send_item(logic [1:0] cmd, det_t d);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'b0, d};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic finish_sending();
        s_axis_tvalid <= 0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        finish_sending();
        drain_results();
        // detections give no records; let the last ones drain
        repeat (1200) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic det_t random_det();
        det_t d;
        det_t src;
        int k;
        d = rand_det_bits();
        k = $urandom_range(0, 9);
        if (k < 6 && recent_boxes.size() > 0) begin
            // jitter a recent box so it tends to match
            src = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
            d.obj_class = src.obj_class;
            d.left = src.left + 16'($urandom_range(0, 60)) - 16'd30;
            d.top = src.top + 16'($urandom_range(0, 60)) - 16'd30;
            d.right = src.right + 16'($urandom_range(0, 60)) - 16'd30;
            d.bottom = src.bottom + 16'($urandom_range(0, 60)) - 16'd30;
        end else if (k < 9) begin
            d.obj_class = 8'($urandom_range(0, 3));
            d.left = 16'($urandom_range(0, 60000));
            d.top = 16'($urandom_range(0, 60000));
            d.right = d.left + 16'($urandom_range(0, 4000));
            d.bottom = d.top + 16'($urandom_range(0, 4000));
        end
        recent_boxes = {recent_boxes, d};
        if (recent_boxes.size() > 12) void'(recent_boxes.pop_front());
        return d;
    endfunction

    task automatic run_frame(int n_det);
        if ($urandom_range(0, 9) != 0) send_item(CMD_START, rand_det_bits());
        for (int k = 0; k < n_det; k++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(CMD_UNUSED, rand_det_bits());
            else
                send_item(CMD_DETECT, random_det());
        end
        if ($urandom_range(0, 9) != 0) send_item(CMD_REPORT, rand_det_bits());
    endtask

    task automatic run_phase(int n_items);
        int goal;
        goal = items_sent + n_items;
        while (items_sent < goal)
            run_frame($urandom_range(0, 10));
        send_item(CMD_REPORT, '0);
    endtask

    initial
    begin
        det_t d;
        sb = new();
        no_idle = 0;
        rx_hold_req = 0;
        items_sent = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_START;
        cfg_we = 0;
        cfg_index = CFG_LOST_LIMIT;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty table
        send_item(CMD_REPORT, '0);

        // full-frame box, exact repeat, degenerate box, unused command
        send_item(CMD_START, '0);
        d = '0;
        d.right = 16'hFFFF;
        d.bottom = 16'hFFFF;
        d.score = 8'hFF;
        d.angle = 12'h800;
        d.distance = 16'hFFFF;
        send_item(CMD_DETECT, d);
        d.score = 8'h00;
        d.angle = 12'h7FF;
        d.distance = 16'h0000;
        send_item(CMD_DETECT, d);
        d.left = 16'hFFFF;
        d.right = 16'h0000;
        send_item(CMD_DETECT, d);
        send_item(CMD_UNUSED, rand_det_bits());
        send_item(CMD_REPORT, '0);

        // fill the table past its size so detections drop
        send_item(CMD_START, '0);
        for (int k = 0; k < 15; k++) begin
            d = rand_det_bits();
            d.obj_class = 8'(10 + k);
            send_item(CMD_DETECT, d);
        end
        send_item(CMD_REPORT, '0);

        write_reg(CFG_LOST_LIMIT, 9'd0);
        write_reg(CFG_MATCH_THRESH, 9'd0);
        write_reg(CFG_BLEND_WEIGHT, 9'd0);
        run_phase(12);

        // age everything until the lost count saturates
        write_reg(CFG_LOST_LIMIT, 9'd255);
        write_reg(CFG_MATCH_THRESH, 9'd256);
        write_reg(CFG_BLEND_WEIGHT, 9'd256);
        run_phase(5);
        for (int k = 0; k < 256; k++) send_item(CMD_START, '0);
        send_item(CMD_REPORT, '0);

        write_reg(CFG_LOST_LIMIT, 9'd2);
        write_reg(CFG_MATCH_THRESH, 9'd511);
        write_reg(CFG_BLEND_WEIGHT, 9'd511);
        run_phase(10);

        // long output stall while input keeps coming
        write_reg(CFG_LOST_LIMIT, 9'd3);
        write_reg(CFG_MATCH_THRESH, 9'd40);
        write_reg(CFG_BLEND_WEIGHT, 9'd64);
        rx_hold_req = 1;
        run_phase(15);
        finish_sending();
        drain_results();
        run_phase(8);

        write_reg(CFG_LOST_LIMIT, 9'd5);
        write_reg(CFG_MATCH_THRESH, 9'd77);
        write_reg(CFG_BLEND_WEIGHT, 9'd128);
        run_phase(10);

        no_idle = 1;
        run_phase(10);
        finish_sending();

        drain_results();
        repeat (1500) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("iou_track_table verification clean");
        else
            $display("iou_track_table verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/iou_pkg.sv
sv/iou_ram.sv
sv/iou_front.sv
sv/iou_back.sv
sv/iou_track_table.sv
verif/iou_track_table_tb.sv
